// ===== rtl/core/json_string_unescape_utf8_top_macros.svh =====
// Assertion macros for the JSON string unescaper.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef JSON_STRING_UNESCAPE_UTF8_TOP_MACROS_SVH
`define JSON_STRING_UNESCAPE_UTF8_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define JSU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define JSU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/jsu_pkg.sv =====
// Shared types and constants of the JSON string unescaper.
// No dependencies; the top level, the decoder and the queue refer to it by scoped name.
package jsu_pkg;

  // Most results one input byte can cause: U+FFFD, one byte, and the unterminated flag.
  localparam int MaxRes       = 5;
  localparam int FifoDepthDef = 4;

  typedef enum logic [1:0] {
    KIND_BYTE   = 2'd0,
    KIND_CLOSE  = 2'd1,
    KIND_BAD    = 2'd2,
    KIND_UNTERM = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  out_byte;
  } res_t;

  typedef struct packed {
    res_t [MaxRes-1:0] res;
    logic [2:0]        cnt;
  } grp_t;

  typedef struct packed {
    logic valid;
    grp_t grp;
  } push_t;

  // Characters of the escape syntax.
  localparam logic [7:0] ChQuote  = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChSlash  = 8'h2F;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChNine   = 8'h39;
  localparam logic [7:0] ChUpA    = 8'h41;
  localparam logic [7:0] ChUpF    = 8'h46;
  localparam logic [7:0] ChLoA    = 8'h61;
  localparam logic [7:0] ChLoF    = 8'h66;
  localparam logic [7:0] ChB      = 8'h62;
  localparam logic [7:0] ChF      = 8'h66;
  localparam logic [7:0] ChN      = 8'h6E;
  localparam logic [7:0] ChR      = 8'h72;
  localparam logic [7:0] ChT      = 8'h74;
  localparam logic [7:0] ChU      = 8'h75;

  // Code point boundaries.
  localparam logic [15:0] HiSurrFirst  = 16'hD800;
  localparam logic [15:0] HiSurrLast   = 16'hDBFF;
  localparam logic [15:0] LoSurrFirst  = 16'hDC00;
  localparam logic [15:0] LoSurrLast   = 16'hDFFF;
  localparam logic [20:0] SuppBase     = 21'h10000;
  localparam logic [20:0] CpReplace    = 21'h0FFFD;

endpackage

// ===== rtl/core/jsu_if.sv =====
// Valid/ready channel interfaces of the JSON string unescaper.
// Depends on nothing; the top level and its submodules use the modports.
interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;

  modport source (output valid, output data_byte, output final_byte, input ready);
  modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

interface jsu_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] out_byte;
  logic       last_of_run;

  modport source (output valid, output kind, output out_byte, output last_of_run, input ready);
  modport sink   (input valid, input kind, input out_byte, input last_of_run, output ready);
endinterface

// ===== rtl/core/json_string_unescape_utf8_top.sv =====
// Top level of the JSON string unescaper with UTF-8 output.
// Depends on jsu_pkg, jsu_if, jsu_decode, jsu_grp_fifo and the assertion macro header.
//
// Feed the bytes of a JSON string body, starting just after the opening quote, on in_ch;
// decoded UTF-8 bytes and status results come out on out_ch, one result per beat, with
// last_of_run marking the last result caused by each input byte. Simple escapes and
// \uXXXX are decoded, surrogate pairs are joined into 4-byte UTF-8, a lone high
// surrogate becomes U+FFFD, a closing quote gives kind 1, a bad escape or hex digit
// gives kind 2, and a final byte that leaves the string open gives kind 3; after any of
// these the block expects a new string. An input byte is accepted every cycle as long
// as the result queue has room: the byte is registered in the input stage, is decoded
// into a group of zero to five results, and the group is written to a queue of
// GrpDepth entries. The first result of a byte is offered on out_ch once its group has
// been registered in the queue. The output port drains one result per cycle while
// out_ch.ready is high; over a long run with out_ch.ready held high the rate is one byte
// per cycle for plain text and set by the total result count where escapes expand,
// with the queue absorbing bursts.
`include "json_string_unescape_utf8_top_macros.svh"

module json_string_unescape_utf8_top #(
  // Result groups buffered between decoder and output; must be at least two.
  parameter int GrpDepth = jsu_pkg::FifoDepthDef
) (
  input  logic      clk,
  input  logic      rst_n,
  jsu_in_if.sink    in_ch,
  jsu_out_if.source out_ch
);

  jsu_pkg::push_t push;
  logic           fifo_full;

  // Output-side conditions watched by the assertions.
  logic out_status;
  logic status_ok;
  logic mid_beat;

  // The decoder holds the escape state and stalls its input stage while the queue is full.
  jsu_decode u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .fifo_full (fifo_full),
    .push      (push)
  );

  // The queue serializes each group onto the output channel.
  jsu_grp_fifo #(
    .Depth (GrpDepth)
  ) u_grp_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .fifo_full (fifo_full),
    .out_ch    (out_ch)
  );

  assign out_status = out_ch.valid && (out_ch.kind != jsu_pkg::KIND_BYTE);
  assign status_ok  = out_ch.last_of_run && (out_ch.out_byte == 8'h00);
  assign mid_beat   = out_ch.valid && out_ch.ready && !out_ch.last_of_run;

  // A group is never written into a full queue.
  `JSU_ASSERT_NOW(a_no_push_when_full, push.valid, !fifo_full, "group pushed into full queue")

  // Close, error and unterminated results always end their run and carry a zero byte.
  `JSU_ASSERT_NOW(a_status_ends_run, out_status, status_ok, "status result malformed")

  // A run that has started keeps the output valid until its last result.
  `JSU_ASSERT_NEXT(a_run_continues, mid_beat, out_ch.valid, "result run broken early")

endmodule

// ===== rtl/core/jsu_decode.sv =====
// Input stage and escape decoder: one byte in, one group of up to five results out.
// Depends on jsu_pkg and jsu_in_if.
module jsu_decode (
  input  logic            clk,
  input  logic            rst_n,
  jsu_in_if.sink          in_ch,
  input  logic            fifo_full,
  output jsu_pkg::push_t  push
);

  typedef enum logic [5:0] {
    M_PLAIN   = 6'b000001,
    M_ESC     = 6'b000010,
    M_HEX     = 6'b000100,
    M_WAIT_BS = 6'b001000,
    M_WAIT_U  = 6'b010000,
    M_LOW_HEX = 6'b100000
  } mode_t;

  typedef struct packed {
    logic [2:0]      n;
    logic [3:0][7:0] b;
  } enc_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] v;
  } hex_t;

  typedef struct packed {
    logic       ok;
    logic [7:0] c;
  } esc_t;

  function automatic enc_t utf8_enc(logic [20:0] cp);
    enc_t e;
    e = '0;
    if (cp < 21'h80) begin
      e.n    = 3'd1;
      e.b[0] = cp[7:0];
    end else if (cp < 21'h800) begin
      e.n    = 3'd2;
      e.b[0] = 8'hC0 | {3'b000, cp[10:6]};
      e.b[1] = 8'h80 | {2'b00, cp[5:0]};
    end else if (cp < 21'h10000) begin
      e.n    = 3'd3;
      e.b[0] = 8'hE0 | {4'h0, cp[15:12]};
      e.b[1] = 8'h80 | {2'b00, cp[11:6]};
      e.b[2] = 8'h80 | {2'b00, cp[5:0]};
    end else begin
      e.n    = 3'd4;
      e.b[0] = 8'hF0 | {5'b00000, cp[20:18]};
      e.b[1] = 8'h80 | {2'b00, cp[17:12]};
      e.b[2] = 8'h80 | {2'b00, cp[11:6]};
      e.b[3] = 8'h80 | {2'b00, cp[5:0]};
    end
    return e;
  endfunction

  function automatic hex_t hex_val(logic [7:0] b);
    hex_t h;
    h = '0;
    if (b >= jsu_pkg::ChZero && b <= jsu_pkg::ChNine) begin
      h.ok = 1'b1;
      h.v  = 4'(b - jsu_pkg::ChZero);
    end else if (b >= jsu_pkg::ChLoA && b <= jsu_pkg::ChLoF) begin
      h.ok = 1'b1;
      h.v  = 4'(b - jsu_pkg::ChLoA) + 4'd10;
    end else if (b >= jsu_pkg::ChUpA && b <= jsu_pkg::ChUpF) begin
      h.ok = 1'b1;
      h.v  = 4'(b - jsu_pkg::ChUpA) + 4'd10;
    end
    return h;
  endfunction

  function automatic esc_t esc_char(logic [7:0] b);
    esc_t e;
    e.ok = 1'b1;
    case (b)
      jsu_pkg::ChQuote:  e.c = jsu_pkg::ChQuote;
      jsu_pkg::ChBslash: e.c = jsu_pkg::ChBslash;
      jsu_pkg::ChSlash:  e.c = jsu_pkg::ChSlash;
      jsu_pkg::ChB:      e.c = 8'h08;
      jsu_pkg::ChF:      e.c = 8'h0C;
      jsu_pkg::ChN:      e.c = 8'h0A;
      jsu_pkg::ChR:      e.c = 8'h0D;
      jsu_pkg::ChT:      e.c = 8'h09;
      default: begin
        e.ok = 1'b0;
        e.c  = 8'h00;
      end
    endcase
    return e;
  endfunction

  // Input stage.
  logic       stage_v_r;
  logic [7:0] stage_byte_r;
  logic       stage_fin_r;
  logic       go;

  // Decoder state.
  mode_t       mode_r, mode_nxt;
  logic [15:0] acc_r, acc_nxt;
  logic [1:0]  dig_r, dig_nxt;
  logic [9:0]  held_r, held_nxt;

  logic             pre_fffd;
  logic             run_plain, run_esc, run_hex, low_part, ended, fin_term;
  logic [2:0]       mn;
  jsu_pkg::kind_t   mk [4];
  logic [3:0][7:0]  mb;
  hex_t             hx;
  esc_t             ec;
  enc_t             enc;
  logic [15:0]      acc_new;
  logic [20:0]      cp;
  logic [2:0]       cnt;
  jsu_pkg::res_t [jsu_pkg::MaxRes-1:0] res;

  assign go          = stage_v_r && !fifo_full;
  assign in_ch.ready = !stage_v_r || !fifo_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_v_r <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      stage_v_r <= 1'b1;
    end else if (go) begin
      stage_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      stage_byte_r <= in_ch.data_byte;
      stage_fin_r  <= in_ch.final_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_PLAIN;
      acc_r  <= '0;
      dig_r  <= '0;
      held_r <= '0;
    end else if (go) begin
      mode_r <= mode_nxt;
      acc_r  <= acc_nxt;
      dig_r  <= dig_nxt;
      held_r <= held_nxt;
    end
  end

  assign hx      = hex_val(stage_byte_r);
  assign ec      = esc_char(stage_byte_r);
  assign acc_new = {acc_r[11:0], hx.v};

  always_comb begin
    mode_nxt  = mode_r;
    acc_nxt   = acc_r;
    dig_nxt   = dig_r;
    held_nxt  = held_r;
    pre_fffd  = 1'b0;
    run_plain = 1'b0;
    run_esc   = 1'b0;
    run_hex   = 1'b0;
    low_part  = 1'b0;
    ended     = 1'b0;
    mn        = '0;
    mb        = '0;
    cp        = '0;
    enc       = '0;
    for (int i = 0; i < 4; i++) begin
      mk[i] = jsu_pkg::KIND_BYTE;
    end

    case (mode_r)
      M_PLAIN: run_plain = 1'b1;
      M_ESC:   run_esc = 1'b1;
      M_HEX:   run_hex = 1'b1;
      M_WAIT_BS: begin
        if (stage_byte_r == jsu_pkg::ChBslash) begin
          mode_nxt = M_WAIT_U;
        end else begin
          pre_fffd  = 1'b1;
          held_nxt  = '0;
          mode_nxt  = M_PLAIN;
          run_plain = 1'b1;
        end
      end
      M_WAIT_U: begin
        if (stage_byte_r == jsu_pkg::ChU) begin
          mode_nxt = M_LOW_HEX;
          acc_nxt  = '0;
          dig_nxt  = '0;
        end else begin
          pre_fffd = 1'b1;
          held_nxt = '0;
          mode_nxt = M_ESC;
          run_esc  = 1'b1;
        end
      end
      M_LOW_HEX: begin
        run_hex  = 1'b1;
        low_part = 1'b1;
      end
      default: begin
        mode_nxt  = M_PLAIN;
        acc_nxt   = '0;
        dig_nxt   = '0;
        held_nxt  = '0;
        run_plain = 1'b1;
      end
    endcase

    if (run_plain) begin
      if (stage_byte_r == jsu_pkg::ChQuote) begin
        mk[0]    = jsu_pkg::KIND_CLOSE;
        mn       = 3'd1;
        ended    = 1'b1;
        mode_nxt = M_PLAIN;
        acc_nxt  = '0;
        dig_nxt  = '0;
        held_nxt = '0;
      end else if (stage_byte_r == jsu_pkg::ChBslash) begin
        mode_nxt = M_ESC;
      end else begin
        mb[0]    = stage_byte_r;
        mn       = 3'd1;
        mode_nxt = M_PLAIN;
      end
    end

    if (run_esc) begin
      if (stage_byte_r == jsu_pkg::ChU) begin
        mode_nxt = M_HEX;
        acc_nxt  = '0;
        dig_nxt  = '0;
      end else if (ec.ok) begin
        mb[0]    = ec.c;
        mn       = 3'd1;
        mode_nxt = M_PLAIN;
      end else begin
        mk[0]    = jsu_pkg::KIND_BAD;
        mn       = 3'd1;
        ended    = 1'b1;
        mode_nxt = M_PLAIN;
        acc_nxt  = '0;
        dig_nxt  = '0;
        held_nxt = '0;
      end
    end

    if (run_hex) begin
      if (!hx.ok) begin
        mk[0]    = jsu_pkg::KIND_BAD;
        mn       = 3'd1;
        ended    = 1'b1;
        mode_nxt = M_PLAIN;
        acc_nxt  = '0;
        dig_nxt  = '0;
        held_nxt = '0;
      end else if (dig_r != 2'd3) begin
        acc_nxt = acc_new;
        dig_nxt = dig_r + 2'd1;
      end else begin
        acc_nxt = '0;
        dig_nxt = '0;
        if (low_part) begin
          if (acc_new >= jsu_pkg::LoSurrFirst && acc_new <= jsu_pkg::LoSurrLast) begin
            cp = jsu_pkg::SuppBase + {1'b0, held_r, acc_new[9:0]};
          end else begin
            cp = jsu_pkg::CpReplace;
          end
          enc      = utf8_enc(cp);
          mn       = enc.n;
          mb       = enc.b;
          mode_nxt = M_PLAIN;
          held_nxt = '0;
        end else if (acc_new >= jsu_pkg::HiSurrFirst && acc_new <= jsu_pkg::HiSurrLast) begin
          held_nxt = acc_new[9:0];
          mode_nxt = M_WAIT_BS;
        end else begin
          cp       = {5'b00000, acc_new};
          enc      = utf8_enc(cp);
          mn       = enc.n;
          mb       = enc.b;
          mode_nxt = M_PLAIN;
        end
      end
    end

    // A final byte that leaves the string open drops any pending escape.
    fin_term = stage_fin_r && !ended;
    if (fin_term) begin
      mode_nxt = M_PLAIN;
      acc_nxt  = '0;
      dig_nxt  = '0;
      held_nxt = '0;
    end
  end

  // Pack the pending replacement, the main results and the open-string flag.
  always_comb begin
    cnt = '0;
    res = '0;
    if (pre_fffd) begin
      res[0] = '{kind: jsu_pkg::KIND_BYTE, out_byte: 8'hEF};
      res[1] = '{kind: jsu_pkg::KIND_BYTE, out_byte: 8'hBF};
      res[2] = '{kind: jsu_pkg::KIND_BYTE, out_byte: 8'hBD};
      cnt    = 3'd3;
    end
    for (int i = 0; i < 4; i++) begin
      if (3'(i) < mn) begin
        res[cnt] = '{kind: mk[i], out_byte: mb[i]};
        cnt      = cnt + 3'd1;
      end
    end
    if (fin_term) begin
      res[cnt] = '{kind: jsu_pkg::KIND_UNTERM, out_byte: 8'h00};
      cnt      = cnt + 3'd1;
    end
  end

  assign push.valid   = go && (cnt != 3'd0);
  assign push.grp.res = res;
  assign push.grp.cnt = cnt;

endmodule

// ===== rtl/core/jsu_grp_fifo.sv =====
// Queue of result groups with a serializer that hands out one result per beat.
// Depends on jsu_pkg and jsu_out_if.
module jsu_grp_fifo #(
  parameter int Depth = jsu_pkg::FifoDepthDef
) (
  input  logic            clk,
  input  logic            rst_n,
  input  jsu_pkg::push_t  push,
  output logic            fifo_full,
  jsu_out_if.source       out_ch
);

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  jsu_pkg::grp_t slot_r [Depth];
  logic [PtrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0] count_r;
  logic [2:0]      idx_r;

  jsu_pkg::grp_t head;
  jsu_pkg::res_t cur;
  logic          beat, last, pop;

  assign head = slot_r[rd_ptr_r];
  assign cur  = head.res[idx_r];
  assign last = (3'(idx_r + 3'd1) == head.cnt);
  assign beat = out_ch.valid && out_ch.ready;
  assign pop  = beat && last;

  assign fifo_full          = (count_r == CntW'(Depth));
  assign out_ch.valid       = (count_r != '0);
  assign out_ch.kind        = cur.kind;
  assign out_ch.out_byte    = cur.out_byte;
  assign out_ch.last_of_run = last;

  always_ff @(posedge clk) begin
    if (push.valid) begin
      slot_r[wr_ptr_r] <= push.grp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
      idx_r    <= '0;
    end else begin
      if (push.valid) begin
        wr_ptr_r <= (wr_ptr_r == PtrW'(Depth - 1)) ? '0 : PtrW'(wr_ptr_r + 1'b1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PtrW'(Depth - 1)) ? '0 : PtrW'(rd_ptr_r + 1'b1);
      end
      if (push.valid && !pop) begin
        count_r <= CntW'(count_r + 1'b1);
      end else if (pop && !push.valid) begin
        count_r <= CntW'(count_r - 1'b1);
      end
      if (pop) begin
        idx_r <= '0;
      end else if (beat) begin
        idx_r <= idx_r + 3'd1;
      end
    end
  end

endmodule
